### hdl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared widths, codes and parameter defaults for the buddy page allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int BLOCK_COUNT_DEF = 4;
  localparam int TREE_LEVELS_DEF = 10;
  localparam int PAGE_BYTES_DEF  = 4096;

  localparam int ADDR_W = 40;
  localparam int CNT_W  = 10;
  localparam int STAT_W = 3;
  localparam int FREE_W = 12;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_ADDR = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd4;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_FLOOR = 1'b1;

endpackage

`default_nettype wire

### hdl/buddy_page_allocator.sv
// ---------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over BLOCK_COUNT page blocks; node values and used marks
// live in two single-port-read synchronous memories.
// ---------------------------------------------------------------------------
// Flow: a bad size is rejected from idle, a bad address after the check
//   state, no space once every block is tried; an alloc descends to a run
//   and updates its ancestors; a free walks the tree to the leaf level.
// Throughput: one command at a time; start is taken again in the strobe cycle.
// Reset: clearing BLOCK_COUNT * 2^TREE_LEVELS entries (4096 by default) loads
//   the trees; busy stays high meanwhile. PAGE_BYTES must be 2^n (unchecked).
`default_nettype none

module buddy_page_allocator #(
  parameter int BLOCK_COUNT = bpa_pkg::BLOCK_COUNT_DEF,
  parameter int TREE_LEVELS = bpa_pkg::TREE_LEVELS_DEF,
  parameter int PAGE_BYTES  = bpa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_command,
  input  wire logic [bpa_pkg::CNT_W-1:0]  in_page_count,
  input  wire logic [bpa_pkg::ADDR_W-1:0] in_address,
  output logic                            out_valid,
  output logic [bpa_pkg::STAT_W-1:0]      out_status,
  output logic [bpa_pkg::ADDR_W-1:0]      out_run_address,
  output logic [bpa_pkg::FREE_W-1:0]      out_free_pages,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [bpa_pkg::ADDR_W-1:0] cfg_data
);
  import bpa_pkg::*;

  localparam int BP    = 1 << (TREE_LEVELS - 1);
  localparam int TL    = TREE_LEVELS;
  localparam int BW    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int AW    = BW + TL;
  localparam int DEPTH = BLOCK_COUNT << TL;
  localparam int DW    = $clog2(TL);
  localparam int PBW   = $clog2(PAGE_BYTES + 1);
  localparam int PBS   = $clog2(PAGE_BYTES);
  localparam int PW    = BW + TL - 1;
  localparam int CW    = ((TL > CNT_W) ? TL : CNT_W) + 1;
  localparam int TOT   = BLOCK_COUNT * BP;
  localparam int TOTW  = ($clog2(TOT + 1) > FREE_W) ? $clog2(TOT + 1) : FREE_W;
  localparam longint SPAN = longint'(BLOCK_COUNT) * BP * PAGE_BYTES;

  localparam logic [TL-1:0]     BP_V    = TL'(BP);
  localparam logic [PBW-1:0]    PB_V    = PBW'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PB_MASK = ADDR_W'(PAGE_BYTES - 1);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_NODE = 4'd2;
  localparam logic [3:0] S_A_LEFT = 4'd3;
  localparam logic [3:0] S_F_CHK  = 4'd5;
  localparam logic [3:0] S_F_TST  = 4'd6;
  localparam logic [3:0] S_F_NEXT = 4'd7;
  localparam logic [3:0] S_UP     = 4'd8;
  localparam logic [3:0] S_A_MUL  = 4'd9;
  localparam logic [3:0] S_A_ADD  = 4'd10;

  logic [TL-1:0] val_mem [DEPTH];
  logic          use_mem [DEPTH];

  logic [3:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [TL-1:0]     size_r, size_nxt;
  logic [ADDR_W-1:0] pa_r, pa_nxt;
  logic [BW-1:0]     blk_r, blk_nxt;
  logic [TL-1:0]     node_r, node_nxt;
  logic [DW-1:0]     dep_r, dep_nxt;
  logic [TL-2:0]     start_r, start_nxt;
  logic [TL-2:0]     p_r, p_nxt;
  logic [TL-1:0]     up_n_r, up_n_nxt;
  logic [DW-1:0]     up_d_r, up_d_nxt;
  logic [TL-1:0]     cval_r, cval_nxt;
  logic              ret_free_r, ret_free_nxt;
  logic              freed_r, freed_nxt;
  logic [TOTW-1:0]   total_r, total_nxt;
  logic [PW+PBW-1:0] prod_r, prod_nxt;
  logic [ADDR_W-1:0] base_r, floor_r;

  logic              val_we, val_re, use_we, use_re;
  logic [AW-1:0]     val_wa, val_ra, use_wa, use_ra;
  logic [TL-1:0]     val_wd, val_rd_r;
  logic              use_wd, use_rd_r;

  logic              fin;
  logic [STAT_W-1:0] fin_status;
  logic [ADDR_W-1:0] fin_addr;

  logic [TL-1:0]     whole, half;
  logic              go_right;
  logic [TL-1:0]     fnode;
  logic [TL-2:0]     fstart;
  logic [CW-1:0]     cnt_x;
  logic              bad_cnt;
  logic [ADDR_W-1:0] diff, off;
  logic [TL-1:0]     par, lv, rv, newv, pwhole;
  logic [DW-1:0]     pdep;
  logic [TL:0]       lr_sum;
  logic              bad_addr, below;

  function automatic logic [TL-1:0] init_val(input logic [TL-1:0] n);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < TL; i++) begin
      if (n[i]) d = DW'(i);
    end
    return BP_V >> d;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // shared per-level values
  assign whole    = BP_V >> dep_r;
  assign half     = whole >> 1;
  assign go_right = ({1'b0, start_r} + {1'b0, half[TL-2:0]}) <= {1'b0, p_r};
  assign fnode    = {node_r[TL-2:0], go_right};
  assign fstart   = go_right ? (start_r + half[TL-2:0]) : start_r;

  assign cnt_x   = CW'(in_page_count);
  assign bad_cnt = (cnt_x == '0) || (cnt_x > CW'(BP)) ||
                   ((in_page_count & (in_page_count - 1'b1)) != '0);

  assign diff = pa_r - base_r;
  assign off  = diff >> PBS;

  assign bad_addr = ((pa_r & PB_MASK) != '0) || (pa_r < floor_r) ||
                    ({1'b0, pa_r} >= ({1'b0, base_r} + 41'(SPAN)));
  assign below    = pa_r < base_r;

  assign par    = up_n_r >> 1;
  assign pdep   = up_d_r - 1'b1;
  assign pwhole = BP_V >> pdep;
  assign lv     = up_n_r[0] ? val_rd_r : cval_r;
  assign rv     = up_n_r[0] ? cval_r : val_rd_r;
  assign lr_sum = {1'b0, lv} + {1'b0, rv};
  assign newv   = (lr_sum == {1'b0, pwhole}) ? pwhole : ((lv > rv) ? lv : rv);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    size_nxt     = size_r;
    pa_nxt       = pa_r;
    blk_nxt      = blk_r;
    node_nxt     = node_r;
    dep_nxt      = dep_r;
    start_nxt    = start_r;
    p_nxt        = p_r;
    up_n_nxt     = up_n_r;
    up_d_nxt     = up_d_r;
    cval_nxt     = cval_r;
    ret_free_nxt = ret_free_r;
    freed_nxt    = freed_r;
    total_nxt    = total_r;
    prod_nxt     = prod_r;
    val_we = 1'b0; val_wa = '0; val_wd = '0;
    val_re = 1'b0; val_ra = '0;
    use_we = 1'b0; use_wa = '0; use_wd = 1'b0;
    use_re = 1'b0; use_ra = '0;
    fin = 1'b0; fin_status = ST_OK; fin_addr = '0;

    unique case (state_r)
      S_CLR: begin
        val_we = 1'b1; val_wa = clr_r; val_wd = init_val(clr_r[TL-1:0]);
        use_we = 1'b1; use_wa = clr_r; use_wd = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_command == CMD_ALLOC) begin
            if (bad_cnt) begin
              fin = 1'b1; fin_status = ST_BAD_SIZE;
            end else begin
              size_nxt  = TL'(cnt_x);
              blk_nxt   = '0;
              node_nxt  = TL'(1);
              dep_nxt   = '0;
              start_nxt = '0;
              val_re = 1'b1; val_ra = {BW'(0), TL'(1)};
              state_nxt = S_A_NODE;
            end
          end else begin
            pa_nxt      = in_address;
            state_nxt   = S_F_CHK;
          end
        end
      end
      S_F_CHK: begin
        if (bad_addr) begin
          fin = 1'b1; fin_status = ST_BAD_ADDR;
        end else if (below) begin
          fin = 1'b1; fin_status = ST_NONE;
        end else begin
          blk_nxt   = off[TL-1 +: BW];
          p_nxt     = off[TL-2:0];
          node_nxt  = TL'(1);
          dep_nxt   = '0;
          start_nxt = '0;
          freed_nxt = 1'b0;
          use_re = 1'b1; use_ra = {off[TL-1 +: BW], TL'(1)};
          state_nxt = S_F_TST;
        end
      end
      S_F_TST, S_F_NEXT: begin
        if (state_r == S_F_TST && start_r == p_r && use_rd_r) begin
          use_we = 1'b1; use_wa = {blk_r, node_r}; use_wd = 1'b0;
          val_we = 1'b1; val_wa = {blk_r, node_r}; val_wd = whole;
          total_nxt = total_r + TOTW'(whole);
          freed_nxt = 1'b1;
          if (node_r != TL'(1)) begin
            up_n_nxt = node_r; up_d_nxt = dep_r; cval_nxt = whole;
            ret_free_nxt = 1'b1;
            val_re = 1'b1; val_ra = {blk_r, node_r ^ TL'(1)};
            state_nxt = S_UP;
          end else begin
            state_nxt = S_F_NEXT;
          end
        end else if (dep_r == DW'(TL - 1)) begin
          fin = 1'b1; fin_status = freed_r ? ST_OK : ST_NONE;
        end else begin
          node_nxt  = fnode;
          start_nxt = fstart;
          dep_nxt   = dep_r + 1'b1;
          use_re = 1'b1; use_ra = {blk_r, fnode};
          state_nxt = S_F_TST;
        end
      end
      S_A_NODE: begin
        if ((dep_r == '0 && val_rd_r < size_r) ||
            (!(val_rd_r == size_r && whole == size_r) && dep_r == DW'(TL - 1))) begin
          if (blk_r == BW'(BLOCK_COUNT - 1)) begin
            fin = 1'b1; fin_status = ST_NO_SPACE;
          end else begin
            blk_nxt = blk_r + 1'b1; node_nxt = TL'(1); dep_nxt = '0; start_nxt = '0;
            val_re = 1'b1; val_ra = {blk_r + 1'b1, TL'(1)};
          end
        end else if (val_rd_r == size_r && whole == size_r) begin
          val_we = 1'b1; val_wa = {blk_r, node_r}; val_wd = '0;
          use_we = 1'b1; use_wa = {blk_r, node_r}; use_wd = 1'b1;
          total_nxt = total_r - TOTW'(size_r);
          if (node_r != TL'(1)) begin
            up_n_nxt = node_r; up_d_nxt = dep_r; cval_nxt = '0;
            ret_free_nxt = 1'b0;
            val_re = 1'b1; val_ra = {blk_r, node_r ^ TL'(1)};
            state_nxt = S_UP;
          end else begin
            state_nxt = S_A_MUL;
          end
        end else begin
          val_re = 1'b1; val_ra = {blk_r, node_r[TL-2:0], 1'b0};
          state_nxt = S_A_LEFT;
        end
      end
      S_A_LEFT: begin
        dep_nxt = dep_r + 1'b1;
        state_nxt = S_A_NODE;
        if (val_rd_r >= size_r) begin
          node_nxt = {node_r[TL-2:0], 1'b0};
        end else begin
          node_nxt  = {node_r[TL-2:0], 1'b1};
          start_nxt = start_r + half[TL-2:0];
          val_re = 1'b1; val_ra = {blk_r, node_r[TL-2:0], 1'b1};
        end
      end
      S_UP: begin
        val_we = 1'b1; val_wa = {blk_r, par}; val_wd = newv;
        up_n_nxt = par; up_d_nxt = pdep; cval_nxt = newv;
        if (par != TL'(1)) begin
          val_re = 1'b1; val_ra = {blk_r, par ^ TL'(1)};
        end else begin
          state_nxt = ret_free_r ? S_F_NEXT : S_A_MUL;
        end
      end
      S_A_MUL: begin
        prod_nxt  = {blk_r, start_r} * PB_V;
        state_nxt = S_A_ADD;
      end
      S_A_ADD: begin
        fin = 1'b1; fin_status = ST_OK;
        fin_addr = base_r + ADDR_W'(prod_r);
      end
      default: state_nxt = S_IDLE;
    endcase
    if (fin) state_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (val_re) val_rd_r <= val_mem[val_ra];
    if (use_we) use_mem[use_wa] <= use_wd;
    if (use_re) use_rd_r <= use_mem[use_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      total_r    <= TOTW'(TOT);
      out_valid  <= 1'b0;
      base_r     <= '0;
      floor_r    <= '0;
      ret_free_r <= 1'b0;
      freed_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      total_r    <= total_nxt;
      out_valid  <= fin;
      ret_free_r <= ret_free_nxt;
      freed_r    <= freed_nxt;
      if (cfg_valid && cfg_index == CFG_BASE)  base_r  <= cfg_data;
      if (cfg_valid && cfg_index == CFG_FLOOR) floor_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    pa_r    <= pa_nxt;
    blk_r   <= blk_nxt;
    node_r  <= node_nxt;
    dep_r   <= dep_nxt;
    start_r <= start_nxt;
    p_r     <= p_nxt;
    up_n_r  <= up_n_nxt;
    up_d_r  <= up_d_nxt;
    cval_r  <= cval_nxt;
    prod_r  <= prod_nxt;
    if (fin) begin
      out_status      <= fin_status;
      out_run_address <= fin_addr;
      out_free_pages  <= total_nxt[FREE_W-1:0];
    end
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe while busy");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLR) |-> (total_r <= TOTW'(TOT)))
    else $error("free page total out of range");

  a_left_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_LEFT) |-> (dep_r < DW'(TL - 1)))
    else $error("descent past leaf level");

  a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
    val_we |-> (val_wd <= BP_V))
    else $error("node value exceeds block pages");

  a_up_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP) |-> (up_n_r > TL'(1)))
    else $error("ancestor update at root");

endmodule

`default_nettype wire
